// File: hw/rtl/srank_pkg.sv
// Shared types and constants for the stack rank error tracker.
// No dependencies; imported by the core, its checker and the testbench.
package srank_pkg;

  localparam int unsigned STACK_DEPTH = 1024;
  localparam int unsigned KEY_BITS    = 32;

  localparam int unsigned ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned FILL_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned KEY_IN_W = 32;
  localparam int unsigned RANK_W  = 10;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned RANK_MAX = 1023;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [FILL_W-1:0]   fill_t;

  typedef enum logic {
    ACT_PUT = 1'b0,
    ACT_GET = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    action_e             action;
    logic [KEY_IN_W-1:0] key;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [RANK_W-1:0] rank;
    logic [RANK_W-1:0] max_rank;
    logic [SUM_W-1:0]  rank_sum;
    logic [CNT_W-1:0]  get_count;
  } rsp_t;

endpackage

// File: hw/rtl/stack_rank_error_tracker_core.sv
// Stack rank error tracker: replays put/get words against a stack held in RAM.
// Depends on srank_pkg and srank_ram.
//
// Use: drive req_i and raise start while busy is low; the word is taken at
// that edge. One result word appears on rsp_o for exactly one cycle with
// done_o high, and is taken at the edge ending that cycle; there is no
// backpressure on the result side.
// done_o is registered and rises in the cycle after the last working cycle of a word.
// A put, a get on an empty stack and a put onto a full stack finish in the
// accept cycle: busy stays low and another word may follow at once.
// A get keeps busy high while it reads down from the top to its key and, if
// the key lies below the top, while it moves the entries above it down one
// place; a get that misses keeps busy high while it reads the whole stack.
// Both passes run through the one read and one write port of the stack RAM,
// one entry per cycle. Reset clears the fill count, the running totals and
// the controller; the stack RAM is not cleared, as only entries below the
// fill count are read. rsp_o carries max_rank, rank_sum and get_count
// after this word's update.
module stack_rank_error_tracker_core
  import srank_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT
  } state_e;

  state_e            state_q, state_d;
  fill_t             fill_q, fill_d;
  addr_t             ptr_q, ptr_d;
  addr_t             rank_q, rank_d;
  key_t              key_q, key_d;
  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [RANK_W-1:0] rank_out_q, rank_out_d;
  logic [RANK_W-1:0] max_q, max_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic              mem_we;
  addr_t             mem_waddr;
  key_t              mem_wdata;
  addr_t             mem_raddr;
  key_t              mem_rdata;

  logic              accept;
  key_t              key_in;
  addr_t             top_addr;
  addr_t             hit_rank;
  logic              fin_get;
  addr_t             fin_rank;
  logic [RANK_W-1:0] fin_rank_sat;
  logic [SUM_W:0]    sum_ext;

  srank_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign accept   = start && (state_q == S_IDLE);
  assign busy     = (state_q != S_IDLE);
  assign key_in   = key_t'(req_i.key);
  assign top_addr = addr_t'(fill_q - fill_t'(1));
  assign hit_rank = top_addr - ptr_q;

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    ptr_d      = ptr_q;
    rank_d     = rank_q;
    key_d      = key_q;
    done_d     = 1'b0;
    status_d   = status_q;
    rank_out_d = rank_out_q;
    mem_we     = 1'b0;
    mem_waddr  = addr_t'(ptr_q - addr_t'(1));
    mem_wdata  = mem_rdata;
    mem_raddr  = ptr_q;
    fin_get    = 1'b0;
    fin_rank   = rank_q;

    case (state_q)
      S_IDLE: begin
        mem_raddr = top_addr;
        if (accept) begin
          key_d = key_in;
          if (req_i.action == ACT_PUT) begin
            done_d     = 1'b1;
            rank_out_d = '0;
            if (fill_q == fill_t'(STACK_DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              status_d  = ST_OK;
              mem_we    = 1'b1;
              mem_waddr = addr_t'(fill_q);
              mem_wdata = key_in;
              fill_d    = fill_q + fill_t'(1);
            end
          end else if (fill_q == '0) begin
            done_d     = 1'b1;
            status_d   = ST_NOT_FOUND;
            rank_out_d = '0;
          end else begin
            ptr_d   = top_addr;
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (mem_rdata == key_q) begin
          if (hit_rank == '0) begin
            fin_get  = 1'b1;
            fin_rank = '0;
            state_d  = S_IDLE;
          end else begin
            rank_d    = hit_rank;
            ptr_d     = ptr_q + addr_t'(1);
            mem_raddr = ptr_q + addr_t'(1);
            state_d   = S_SHIFT;
          end
        end else if (ptr_q == '0) begin
          done_d     = 1'b1;
          status_d   = ST_NOT_FOUND;
          rank_out_d = '0;
          state_d    = S_IDLE;
        end else begin
          ptr_d     = ptr_q - addr_t'(1);
          mem_raddr = ptr_q - addr_t'(1);
        end
      end
      S_SHIFT: begin
        mem_we = 1'b1;
        if (ptr_q == top_addr) begin
          fin_get = 1'b1;
          state_d = S_IDLE;
        end else begin
          ptr_d     = ptr_q + addr_t'(1);
          mem_raddr = ptr_q + addr_t'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign fin_rank_sat = (32'(fin_rank) > 32'(RANK_MAX)) ? RANK_W'(RANK_MAX)
                                                         : RANK_W'(fin_rank);
  assign sum_ext      = {1'b0, sum_q} + (SUM_W + 1)'(fin_rank);

  always_comb begin
    max_d = max_q;
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (fin_get) begin
      if (fin_rank_sat > max_q) begin
        max_d = fin_rank_sat;
      end
      sum_d = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      if (cnt_q != '1) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      fill_q     <= '0;
      done_q     <= 1'b0;
      max_q      <= '0;
      sum_q      <= '0;
      cnt_q      <= '0;
      status_q   <= ST_OK;
      rank_out_q <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fin_get ? fill_q - fill_t'(1) : fill_d;
      done_q  <= done_d || fin_get;
      max_q   <= max_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      if (fin_get) begin
        status_q   <= ST_OK;
        rank_out_q <= fin_rank_sat;
      end else begin
        status_q   <= status_d;
        rank_out_q <= rank_out_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    rank_q <= rank_d;
    key_q  <= key_d;
  end

  assign done_o          = done_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.rank      = rank_out_q;
  assign rsp_o.max_rank  = max_q;
  assign rsp_o.rank_sum  = sum_q;
  assign rsp_o.get_count = cnt_q;

endmodule

// File: hw/rtl/srank_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srank_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/srank_checker.sv
// Port-level checker for the stack rank error tracker, bound to the core.
// Depends on srank_pkg and stack_rank_error_tracker_core.
module srank_checker
  import srank_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input rsp_t rsp_o
);

  a_accept_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("accepted word neither finished nor held busy");

  a_error_rank_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |-> (rsp_o.rank == '0))
    else $error("failed word reports a non-zero rank");

  a_max_covers_rank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.max_rank >= rsp_o.rank))
    else $error("max_rank below this word's rank");

  a_status_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.status == ST_OK || rsp_o.status == ST_NOT_FOUND ||
                rsp_o.status == ST_FULL))
    else $error("result status outside the defined codes");

endmodule

bind stack_rank_error_tracker_core srank_checker u_srank_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .rsp_o (rsp_o)
);

// File: bench/stack_rank_error_tracker_core_test.sv
// Testbench for stack_rank_error_tracker_core: directed table and random put/get traffic,
// each result word checked against its typed table row or else an in-bench stack replay.
// Depends on srank_pkg and the core RTL only.
module stack_rank_error_tracker_core_test;
  import srank_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    req_t word;
    bit   typed;
    rsp_t rsp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t req_i = '0;
  logic busy;
  logic done_o;
  rsp_t rsp_o;

  key_t              stack_model [STACK_DEPTH];
  int                model_fill = 0;
  logic [RANK_W-1:0] model_max = '0;
  logic [SUM_W-1:0]  model_sum = '0;
  logic [CNT_W-1:0]  model_gets = '0;

  rsp_t rsp_due [$];
  rsp_t due_w;
  int   fails = 0;
  int   idle_pct = 34;

  row_t script [18] = '{
    '{'{ACT_GET, 32'h0000_0000}, 1'b1, '{ST_NOT_FOUND, 10'd0, 10'd0, 48'd0, 32'd0}},
    '{'{ACT_PUT, 32'hFFFF_FFFF}, 1'b1, '{ST_OK, 10'd0, 10'd0, 48'd0, 32'd0}},
    '{'{ACT_PUT, 32'h0000_0000}, 1'b1, '{ST_OK, 10'd0, 10'd0, 48'd0, 32'd0}},
    '{'{ACT_PUT, 32'hAAAA_AAAA}, 1'b1, '{ST_OK, 10'd0, 10'd0, 48'd0, 32'd0}},
    '{'{ACT_PUT, 32'h5555_5555}, 1'b1, '{ST_OK, 10'd0, 10'd0, 48'd0, 32'd0}},
    '{'{ACT_PUT, 32'h0000_0000}, 1'b1, '{ST_OK, 10'd0, 10'd0, 48'd0, 32'd0}},
    '{'{ACT_GET, 32'h1234_5678}, 1'b1, '{ST_NOT_FOUND, 10'd0, 10'd0, 48'd0, 32'd0}},
    '{'{ACT_GET, 32'h0000_0000}, 1'b1, '{ST_OK, 10'd0, 10'd0, 48'd0, 32'd1}},
    '{'{ACT_GET, 32'hFFFF_FFFF}, 1'b1, '{ST_OK, 10'd3, 10'd3, 48'd3, 32'd2}},
    '{'{ACT_GET, 32'h0000_0000}, 1'b1, '{ST_OK, 10'd2, 10'd3, 48'd5, 32'd3}},
    '{'{ACT_GET, 32'h0000_0000}, 1'b1, '{ST_NOT_FOUND, 10'd0, 10'd3, 48'd5, 32'd3}},
    '{'{ACT_PUT, 32'h8000_0000}, 1'b0, '0},
    '{'{ACT_PUT, 32'h0000_0001}, 1'b0, '0},
    '{'{ACT_GET, 32'h5555_5555}, 1'b0, '0},
    '{'{ACT_GET, 32'h8000_0000}, 1'b0, '0},
    '{'{ACT_GET, 32'hAAAA_AAAA}, 1'b0, '0},
    '{'{ACT_GET, 32'h0000_0001}, 1'b0, '0},
    '{'{ACT_GET, 32'h0000_0001}, 1'b0, '0}
  };

  stack_rank_error_tracker_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic rsp_t replay_word(req_t w);
    rsp_t r;
    key_t k;
    int   pos;
    int   above;
    bit   hit;
    k = key_t'(w.key);
    r = '0;
    r.status = ST_OK;
    hit = 1'b0;
    pos = model_fill;
    if (w.action == ACT_PUT) begin
      if (model_fill >= STACK_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        stack_model[model_fill] = k;
        model_fill++;
      end
    end else begin
      while (pos > 0 && !hit) begin
        pos--;
        hit = (stack_model[pos] == k);
      end
      if (!hit) begin
        r.status = ST_NOT_FOUND;
      end else begin
        above = model_fill - 1 - pos;
        for (int i = pos; i + 1 < model_fill; i++) stack_model[i] = stack_model[i + 1];
        model_fill--;
        r.rank = (above > RANK_MAX) ? RANK_W'(RANK_MAX) : RANK_W'(above);
        if (r.rank > model_max) model_max = r.rank;
        if (model_sum > {SUM_W{1'b1}} - SUM_W'(above)) model_sum = '1;
        else model_sum = model_sum + SUM_W'(above);
        if (model_gets != '1) model_gets = model_gets + 1'b1;
      end
    end
    r.max_rank  = model_max;
    r.rank_sum  = model_sum;
    r.get_count = model_gets;
    return r;
  endfunction

  task automatic send_word(input req_t w, input bit typed, input rsp_t typed_rsp);
    rsp_t predicted;
    start <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (busy);
    predicted = replay_word(w);
    rsp_due.insert(rsp_due.size(), typed ? typed_rsp : predicted);
  endtask

  task automatic random_idle();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (rsp_due.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (rsp_due.size() == 0) begin
        $display("%0t: result word with none expected: %h", $time, rsp_o);
        fails++;
      end else begin
        due_w = rsp_due.pop_front();
        if (rsp_o.status !== due_w.status) begin
          $display("%0t: status expected %0d actual %0d", $time, due_w.status, rsp_o.status);
          fails++;
        end
        if (rsp_o.rank !== due_w.rank) begin
          $display("%0t: rank expected %0d actual %0d", $time, due_w.rank, rsp_o.rank);
          fails++;
        end
        if (rsp_o.max_rank !== due_w.max_rank) begin
          $display("%0t: max_rank expected %0d actual %0d", $time, due_w.max_rank,
                   rsp_o.max_rank);
          fails++;
        end
        if (rsp_o.rank_sum !== due_w.rank_sum) begin
          $display("%0t: rank_sum expected %0d actual %0d", $time, due_w.rank_sum,
                   rsp_o.rank_sum);
          fails++;
        end
        if (rsp_o.get_count !== due_w.get_count) begin
          $display("%0t: get_count expected %0d actual %0d", $time, due_w.get_count,
                   rsp_o.get_count);
          fails++;
        end
      end
    end
  end

  initial begin
    #250ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    req_t w;
    int   r;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      random_idle();
      send_word(script[i].word, script[i].typed, script[i].rsp);
    end
    drain();

    for (int n = 0; n < 562; n++) begin
      idle_pct = (n >= 200 && n < 330) ? 0 : 34;
      random_idle();
      r = $urandom_range(99);
      if (model_fill == 0) w.action = (r < 85) ? ACT_PUT : ACT_GET;
      else if (model_fill >= 48) w.action = (r < 30) ? ACT_PUT : ACT_GET;
      else w.action = (r < 55) ? ACT_PUT : ACT_GET;
      r = $urandom_range(99);
      if (model_fill > 0 && ((w.action == ACT_GET && r < 70) || (w.action == ACT_PUT && r < 10)))
        w.key = stack_model[$urandom_range(model_fill - 1)];
      else if (r < 85) w.key = $urandom_range(15);
      else w.key = $urandom;
      send_word(w, 1'b0, '0);
    end
    idle_pct = 34;

    drain();
    repeat (2 * STACK_DEPTH + 4) @(posedge clk_i);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: stack_rank_error_tracker_core.f
hw/rtl/srank_pkg.sv
hw/rtl/srank_ram.sv
hw/rtl/stack_rank_error_tracker_core.sv
hw/rtl/srank_checker.sv
bench/stack_rank_error_tracker_core_test.sv
